/* rtl/core/ibpd_pkg.sv */
// ----------------------------------------------------------------------------
// ibpd_pkg
// Types and constants shared by the IEC 61937 burst preamble detector.
// ----------------------------------------------------------------------------
package ibpd_pkg;

   // Sync words
   localparam logic [15:0] PA_WORD = 16'hF872;
   localparam logic [15:0] PB_WORD = 16'h4E1F;

   // Configuration reset values
   localparam logic [9:0]  BLOCK_SUBFRAMES_RESET     = 10'd384;
   localparam logic [5:0]  BURST_PERIOD_BLOCKS_RESET = 6'd32;
   localparam logic [15:0] ALTERNATE_PB_WORD_RESET   = 16'h4E3E;

   localparam logic [9:0]  SAMPLE_COUNT_MAX = 10'd1023;

   // Configuration register indexes
   localparam logic [1:0] CSR_BLOCK_SUBFRAMES     = 2'd0;
   localparam logic [1:0] CSR_BURST_PERIOD_BLOCKS = 2'd1;
   localparam logic [1:0] CSR_ALTERNATE_PB_WORD   = 2'd2;

   // Operation codes
   localparam logic OP_AUDIO  = 1'b0;
   localparam logic OP_STATUS = 1'b1;

   // Preamble types
   localparam logic [1:0] FT_INVALID = 2'd0;
   localparam logic [1:0] FT_B       = 2'd1;
   localparam logic [1:0] FT_M       = 2'd2;
   localparam logic [1:0] FT_W       = 2'd3;

   // Event codes
   localparam logic [1:0] SYNC_NONE     = 2'd0;
   localparam logic [1:0] SYNC_EXPECTED = 2'd1;
   localparam logic [1:0] SYNC_WRONG    = 2'd2;

   localparam logic [1:0] EVT_NONE     = 2'd0;
   localparam logic [1:0] EVT_ACCEPTED = 2'd1;
   localparam logic [1:0] EVT_REJECTED = 2'd2;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_GOT_PA = 5'b00010,
      ST_SKIP_M = 5'b00100,
      ST_GOT_PB = 5'b01000,
      ST_GOT_PC = 5'b10000
   } preamble_state_type;

   typedef struct packed {
      logic [9:0]  block_subframes;
      logic [5:0]  burst_period_blocks;
      logic [15:0] alternate_pb_word;
   } cfg_type;

   typedef struct packed {
      logic        operation;
      logic [1:0]  frame_type;
      logic [31:0] subframe_word;
      logic [47:0] start_time;
      logic [47:0] end_time;
      logic        status_nonaudio_bit;
   } req_payload_type;

   typedef struct packed {
      logic [15:0] sample_word;
      logic        gap_found;
      logic [47:0] gap_length;
      logic [1:0]  block_sync_event;
      logic        pa_found;
      logic [1:0]  pc_event;
      logic [1:0]  pd_event;
      logic        burst_found;
      logic [4:0]  burst_data_type;
      logic [15:0] burst_length;
      logic [47:0] burst_start;
      logic        non_audio;
   } rsp_payload_type;

endpackage

/* rtl/core/ibpd_stream_if.sv */
// ----------------------------------------------------------------------------
// ibpd_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface ibpd_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/core/ibpd_csr.sv */
// ----------------------------------------------------------------------------
// ibpd_csr
// Configuration registers, written through a plain write port.
// ----------------------------------------------------------------------------
module ibpd_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_enable,
   input  logic [1:0]       csr_index,
   input  logic [15:0]      csr_write_data,
   output ibpd_pkg::cfg_type cfg
);
   import ibpd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_BLOCK_SUBFRAMES:     cfg_in.block_subframes     = csr_write_data[9:0];
            CSR_BURST_PERIOD_BLOCKS: cfg_in.burst_period_blocks = csr_write_data[5:0];
            CSR_ALTERNATE_PB_WORD:   cfg_in.alternate_pb_word   = csr_write_data;
            default: ; // no register here: drop the write
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.block_subframes     <= BLOCK_SUBFRAMES_RESET;
         cfg_ff.burst_period_blocks <= BURST_PERIOD_BLOCKS_RESET;
         cfg_ff.alternate_pb_word   <= ALTERNATE_PB_WORD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/core/ibpd_core.sv */
// ----------------------------------------------------------------------------
// ibpd_core
// Detector state and the single-pass update for one item.
// ----------------------------------------------------------------------------
module ibpd_core (
   input  logic                      clock,
   input  logic                      reset,
   input  ibpd_pkg::cfg_type         cfg,
   input  logic                      advance,
   input  ibpd_pkg::req_payload_type item,
   output ibpd_pkg::rsp_payload_type result
);
   import ibpd_pkg::*;

   preamble_state_type state_ff, state_in;
   logic [4:0]  held_type_ff, held_type_in;
   logic [47:0] held_start_ff, held_start_in;
   logic [9:0]  sample_cnt_ff, sample_cnt_in;
   logic [5:0]  sync_cnt_ff, sync_cnt_in;
   logic        seen_ff, seen_in;
   logic        nonaudio_ff, nonaudio_in;
   logic [47:0] prev_end_ff, prev_end_in;

   logic        validity;
   logic [15:0] w16;
   logic        is_b, is_m, is_w, m_or_b;
   logic        pb_match, pa_match;
   logic [9:0]  cnt_inc;
   logic [6:0]  sync_plus;
   logic        at_boundary;
   preamble_state_type state_mid;
   logic [4:0]  held_type_mid;

   always_comb begin
      validity = item.subframe_word[28];
      w16      = item.subframe_word[27:12];
      is_b     = (item.frame_type == FT_B);
      is_m     = (item.frame_type == FT_M);
      is_w     = (item.frame_type == FT_W);
      m_or_b   = is_b || is_m;
      pa_match = (w16 == PA_WORD);
      pb_match = (w16 == PB_WORD) || (w16 == cfg.alternate_pb_word);
      cnt_inc  = (sample_cnt_ff < SAMPLE_COUNT_MAX) ? sample_cnt_ff + 10'd1 : sample_cnt_ff;
      sync_plus = {1'b0, sync_cnt_ff} + 7'd1;

      state_in      = state_ff;
      held_type_in  = held_type_ff;
      held_start_in = held_start_ff;
      sample_cnt_in = sample_cnt_ff;
      sync_cnt_in   = sync_cnt_ff;
      seen_in       = seen_ff;
      nonaudio_in   = nonaudio_ff;
      prev_end_in   = prev_end_ff;
      state_mid     = state_ff;
      held_type_mid = held_type_ff;
      at_boundary   = 1'b0;
      result        = '0;

      if (item.operation == OP_STATUS) begin
         if (item.status_nonaudio_bit) begin
            nonaudio_in = 1'b1;
         end else if (!seen_ff) begin
            nonaudio_in = 1'b0;
         end
      end else begin
         result.sample_word = w16;
         if (prev_end_ff != item.start_time && prev_end_ff != '0 &&
             !(validity || nonaudio_ff)) begin
            result.gap_found  = 1'b1;
            result.gap_length = item.start_time - prev_end_ff;
         end

         sample_cnt_in = cnt_inc;
         if (is_b) begin
            result.block_sync_event = (cnt_inc == cfg.block_subframes) ?
                                      SYNC_EXPECTED : SYNC_WRONG;
            sample_cnt_in = '0;
            sync_cnt_in   = (sync_plus >= {1'b0, cfg.burst_period_blocks}) ?
                            6'd0 : sync_plus[5:0];
            // A B preamble aborts any preamble in progress
            state_mid     = ST_IDLE;
            held_type_mid = '0;
         end

         if (validity) begin
            nonaudio_in = 1'b1;
         end

         at_boundary  = !seen_ff || (sync_cnt_in == 6'd0);
         state_in     = state_mid;
         held_type_in = held_type_mid;

         unique case (state_mid)
            ST_IDLE: begin
               // Pa only at a B sync (counter just cleared) on a period boundary or before the first burst
               if (pa_match && is_b && at_boundary) begin
                  state_in      = ST_GOT_PA;
                  held_start_in = item.start_time;
                  result.pa_found = 1'b1;
               end
            end
            ST_GOT_PA: begin
               if (is_m) begin
                  state_in = ST_SKIP_M;
               end else if (is_w) begin
                  if (pb_match) begin
                     state_in = ST_GOT_PB;
                  end else if (pa_match) begin
                     held_start_in   = item.start_time;
                     result.pa_found = 1'b1;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  state_in = ST_IDLE;
               end
            end
            ST_SKIP_M: begin
               state_in = (is_w && pb_match) ? ST_GOT_PB : ST_IDLE;
            end
            ST_GOT_PB: begin
               if (m_or_b) begin
                  held_type_in    = w16[4:0];
                  state_in        = ST_GOT_PC;
                  result.pc_event = EVT_ACCEPTED;
               end else begin
                  state_in        = ST_IDLE;
                  result.pc_event = EVT_REJECTED;
               end
            end
            ST_GOT_PC: begin
               if (!is_w) begin
                  state_in        = ST_IDLE;
                  result.pd_event = EVT_REJECTED;
               end else begin
                  result.pd_event        = EVT_ACCEPTED;
                  result.burst_found     = 1'b1;
                  result.burst_data_type = held_type_mid;
                  result.burst_length    = w16;
                  result.burst_start     = held_start_ff;
                  seen_in      = 1'b1;
                  sync_cnt_in  = '0;
                  nonaudio_in  = 1'b1;
                  state_in     = ST_IDLE;
                  held_type_in = '0;
               end
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase

         prev_end_in = item.end_time;
      end

      result.non_audio = nonaudio_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         held_type_ff  <= '0;
         held_start_ff <= '0;
         sample_cnt_ff <= '0;
         sync_cnt_ff   <= '0;
         seen_ff       <= 1'b0;
         nonaudio_ff   <= 1'b0;
         prev_end_ff   <= '0;
      end else if (advance) begin
         state_ff      <= state_in;
         held_type_ff  <= held_type_in;
         held_start_ff <= held_start_in;
         sample_cnt_ff <= sample_cnt_in;
         sync_cnt_ff   <= sync_cnt_in;
         seen_ff       <= seen_in;
         nonaudio_ff   <= nonaudio_in;
         prev_end_ff   <= prev_end_in;
      end
   end

endmodule

/* rtl/core/iec61937_burst_preamble_detector.sv */
// ----------------------------------------------------------------------------
// iec61937_burst_preamble_detector
// A request transaction is accepted into the request register, passes the
// compare and update logic and is held in the result register until taken.
// Throughput: one request transaction per cycle unless the result register
// is full and stalled; set by the single pass of compare and update logic.
// Reset (synchronous, active high) empties both registers, returns the
// preamble tracker to idle, clears all counters and flags and loads the
// configuration defaults.
// ----------------------------------------------------------------------------
module iec61937_burst_preamble_detector (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_write_data,
   ibpd_stream_if.sink   req_chan,
   ibpd_stream_if.source rsp_chan
);
   import ibpd_pkg::*;

   cfg_type         cfg;
   req_payload_type req_item_ff;
   logic            req_valid_ff;
   rsp_payload_type rsp_item_ff;
   logic            rsp_valid_ff;
   rsp_payload_type step_result;
   logic            rsp_load;
   logic            advance;

   // Configuration register file
   ibpd_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   // Result register can take a new value when empty or being drained
   assign rsp_load = !rsp_valid_ff || rsp_chan.ready;
   // Move the held request through the update logic into the result register
   assign advance  = req_valid_ff && rsp_load;
   // Accept a new request whenever the request register empties this cycle
   assign req_chan.ready = !req_valid_ff || advance;

   // Detector state and single-pass update
   ibpd_core u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .advance (advance),
      .item    (req_item_ff),
      .result  (step_result)
   );

   // Request register: hold the accepted transaction until it advances
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         req_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         req_item_ff <= req_chan.payload;
      end
   end

   // Result register: hold the result until the consumer takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_item_ff <= step_result;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_item_ff;

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the IEC 61937 burst preamble detector. Drives
// S/PDIF subframe and channel-status transactions through the request
// channel, predicts every report in a scoreboard and compares each report
// field by field as it leaves the result channel. Directed cases alternate
// with randomized subframe streams, with or without Pa/Pb/Pc/Pd bursts,
// corruption and noise, under several register settings and backpressure mixes.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ibpd_pkg::*;

   // -------------------------------------------------------------------------
   // Scoreboard: a cycle-free model of the detector plus the queue of reports
   // it still owes.
   // -------------------------------------------------------------------------
   class preamble_scoreboard;
      // register copies
      logic [9:0]         block_len;
      logic [5:0]         period;
      logic [15:0]        alt_pb;
      // tracker state
      preamble_state_type tracker_state;
      logic [4:0]         held_type;
      logic [47:0]        held_start;
      logic [9:0]         sample_count;
      logic [5:0]         sync_count;
      logic               burst_seen;
      logic               nonaudio;
      logic [47:0]        prev_end;

      rsp_payload_type    expected_detections[$];
      int                 errors;

      function new();
         block_len     = BLOCK_SUBFRAMES_RESET;
         period        = BURST_PERIOD_BLOCKS_RESET;
         alt_pb        = ALTERNATE_PB_WORD_RESET;
         tracker_state = ST_IDLE;
         held_type     = '0;
         held_start    = '0;
         sample_count  = '0;
         sync_count    = '0;
         burst_seen    = 1'b0;
         nonaudio      = 1'b0;
         prev_end      = '0;
         errors        = 0;
      endfunction

      function void write_register(logic [1:0] idx, logic [15:0] data);
         case (idx)
            CSR_BLOCK_SUBFRAMES:     block_len = data[9:0];
            CSR_BURST_PERIOD_BLOCKS: period    = data[5:0];
            CSR_ALTERNATE_PB_WORD:   alt_pb    = data;
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_detections.size();
      endfunction

      function logic is_pb(logic [15:0] w);
         return (w == PB_WORD) || (w == alt_pb);
      endfunction

      function rsp_payload_type predict_detection(req_payload_type q);
         rsp_payload_type r;
         logic            validity;
         logic            m_or_b;
         logic            is_w;
         logic            at_block_start;
         logic            at_boundary;
         logic [15:0]     w16;
         logic [6:0]      next_sync;
         r = '0;
         if (q.operation == OP_STATUS) begin
            // status only touches the non-audio flag; it cannot drop it once
            // a burst has been seen
            if (q.status_nonaudio_bit) nonaudio = 1'b1;
            else if (!burst_seen) nonaudio = 1'b0;
            r.non_audio = nonaudio;
            return r;
         end
         validity      = q.subframe_word[28];
         w16           = q.subframe_word[27:12];
         m_or_b        = (q.frame_type == FT_M) || (q.frame_type == FT_B);
         is_w          = (q.frame_type == FT_W);
         r.sample_word = w16;

         if (prev_end != q.start_time && prev_end != '0 && !(validity || nonaudio)) begin
            r.gap_found  = 1'b1;
            r.gap_length = q.start_time - prev_end;
         end

         if (sample_count < SAMPLE_COUNT_MAX) sample_count = sample_count + 10'd1;

         if (q.frame_type == FT_B) begin
            r.block_sync_event = (sample_count == block_len) ? SYNC_EXPECTED : SYNC_WRONG;
            sample_count = '0;
            next_sync    = {1'b0, sync_count} + 7'd1;
            if (next_sync >= {1'b0, period}) sync_count = '0;
            else sync_count = next_sync[5:0];
            if (tracker_state != ST_IDLE) begin
               tracker_state = ST_IDLE;
               held_type     = '0;
            end
         end

         if (validity) nonaudio = 1'b1;

         at_block_start = (sample_count == '0);
         at_boundary    = !burst_seen || (sync_count == '0);

         case (tracker_state)
            ST_IDLE: begin
               if (w16 == PA_WORD && m_or_b && at_block_start && at_boundary) begin
                  tracker_state = ST_GOT_PA;
                  held_start    = q.start_time;
                  r.pa_found    = 1'b1;
               end
            end
            ST_GOT_PA: begin
               if (q.frame_type == FT_M) begin
                  tracker_state = ST_SKIP_M;
               end else if (is_w) begin
                  // Pb match takes priority over a repeated Pa
                  if (is_pb(w16)) begin
                     tracker_state = ST_GOT_PB;
                  end else if (w16 == PA_WORD) begin
                     held_start = q.start_time;
                     r.pa_found = 1'b1;
                  end else begin
                     tracker_state = ST_IDLE;
                  end
               end else begin
                  tracker_state = ST_IDLE;
               end
            end
            ST_SKIP_M: begin
               tracker_state = (is_w && is_pb(w16)) ? ST_GOT_PB : ST_IDLE;
            end
            ST_GOT_PB: begin
               if (m_or_b) begin
                  held_type     = w16[4:0];
                  tracker_state = ST_GOT_PC;
                  r.pc_event    = EVT_ACCEPTED;
               end else begin
                  tracker_state = ST_IDLE;
                  r.pc_event    = EVT_REJECTED;
               end
            end
            ST_GOT_PC: begin
               if (!is_w) begin
                  tracker_state = ST_IDLE;
                  r.pd_event    = EVT_REJECTED;
               end else begin
                  r.pd_event        = EVT_ACCEPTED;
                  r.burst_found     = 1'b1;
                  r.burst_data_type = held_type;
                  r.burst_length    = w16;
                  r.burst_start     = held_start;
                  burst_seen        = 1'b1;
                  sync_count        = '0;
                  nonaudio          = 1'b1;
                  tracker_state     = ST_IDLE;
                  held_type         = '0;
               end
            end
            default: tracker_state = ST_IDLE;
         endcase

         prev_end    = q.end_time;
         r.non_audio = nonaudio;
         return r;
      endfunction

      function void note_request(req_payload_type q);
         expected_detections.push_back(predict_detection(q));
      endfunction

      function void compare_field(string name, logic [47:0] want, logic [47:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         end
      endfunction

      function void check_detection(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_detections.size() == 0) begin
            errors++;
            $display("%0t: unexpected report, expected none, actual %h", $time, got);
            return;
         end
         want = expected_detections.pop_front();
         compare_field("sample_word",      want.sample_word,      got.sample_word);
         compare_field("gap_found",        want.gap_found,        got.gap_found);
         compare_field("gap_length",       want.gap_length,       got.gap_length);
         compare_field("block_sync_event", want.block_sync_event, got.block_sync_event);
         compare_field("pa_found",         want.pa_found,         got.pa_found);
         compare_field("pc_event",         want.pc_event,         got.pc_event);
         compare_field("pd_event",         want.pd_event,         got.pd_event);
         compare_field("burst_found",      want.burst_found,      got.burst_found);
         compare_field("burst_data_type",  want.burst_data_type,  got.burst_data_type);
         compare_field("burst_length",     want.burst_length,     got.burst_length);
         compare_field("burst_start",      want.burst_start,      got.burst_start);
         compare_field("non_audio",        want.non_audio,        got.non_audio);
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // DUT and channels
   // -------------------------------------------------------------------------
   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [1:0]  csr_index;
   logic [15:0] csr_write_data;

   ibpd_stream_if #(.payload_type(req_payload_type)) req_chan ();
   ibpd_stream_if #(.payload_type(rsp_payload_type)) rsp_chan ();

   iec61937_burst_preamble_detector u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan)
   );

   preamble_scoreboard sb;

   // backpressure mix, switched as the run advances
   int          send_idle_pct = 10;
   int          recv_idle_pct = 72;
   int          items_sent    = 0;
   // percentage of stream subframes that start off the previous end time
   int          gap_pct       = 0;
   // end time of the last stream subframe
   logic [47:0] time_cursor;

   // 4 ns clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Receiver: toggle ready at random according to the current mix.
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Check every result transaction against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         sb.check_detection(rsp_chan.payload);
   end

   // Hard stop in case the DUT hangs.
   initial begin
      #2000000;
      $display("Verification failed");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------
   function automatic logic [47:0] rand48();
      logic [63:0] v;
      v = {$urandom, $urandom};
      return v[47:0];
   endfunction

   // Place the 16-bit word at bits 27:12; fill the rest with noise.
   function automatic logic [31:0] make_word(logic validity, logic [15:0] w16);
      logic [31:0] rnd;
      rnd = $urandom;
      return {rnd[31:29], validity, w16, rnd[11:0]};
   endfunction

   function automatic req_payload_type audio_item(logic [1:0] ft, logic [31:0] word,
                                                  logic [47:0] st, logic [47:0] en);
      req_payload_type p;
      p.operation           = OP_AUDIO;
      p.frame_type          = ft;
      p.subframe_word       = word;
      p.start_time          = st;
      p.end_time            = en;
      p.status_nonaudio_bit = 1'($urandom_range(1));
      return p;
   endfunction

   // Status event; every field but the flag is don't-care, so randomize it.
   function automatic req_payload_type status_item(logic flag);
      req_payload_type p;
      p.operation           = OP_STATUS;
      p.frame_type          = 2'($urandom_range(3));
      p.subframe_word       = $urandom;
      p.start_time          = rand48();
      p.end_time            = rand48();
      p.status_nonaudio_bit = flag;
      return p;
   endfunction

   function automatic req_payload_type random_item();
      req_payload_type p;
      p.operation           = 1'($urandom_range(1));
      p.frame_type          = 2'($urandom_range(3));
      p.subframe_word       = $urandom;
      p.start_time          = rand48();
      p.end_time            = rand48();
      p.status_nonaudio_bit = 1'($urandom_range(1));
      return p;
   endfunction

   // Offer one request transaction; hold it until accepted.
   task automatic send_item(input req_payload_type p);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= p;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sb.note_request(p);
      items_sent++;
      // receiver-heavy idling first, then sender-heavy, then none
      if (items_sent < 220) begin
         send_idle_pct = 10;
         recv_idle_pct = 72;
      end else if (items_sent < 440) begin
         send_idle_pct = 72;
         recv_idle_pct = 10;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
   endtask

   // Drop valid and hold off until every predicted report has come back.
   task automatic wait_for_drain();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [15:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      sb.write_register(idx, data);
   endtask

   // Reprogram all registers with the block idle; pad unused upper bits with
   // noise, the DUT must ignore them.
   task automatic set_config(input logic [9:0] blk, input logic [5:0] per,
                             input logic [15:0] alt);
      logic [15:0] rnd;
      rnd = 16'($urandom);
      wait_for_drain();
      write_csr(CSR_BLOCK_SUBFRAMES, {rnd[15:10], blk});
      write_csr(CSR_BURST_PERIOD_BLOCKS, {rnd[15:6], per});
      write_csr(CSR_ALTERNATE_PB_WORD, alt);
      csr_write_enable <= 1'b0;
   endtask

   // One subframe on the running timeline; occasionally jump the start time.
   task automatic send_subframe(input logic [1:0] ft, input logic validity,
                                input logic [15:0] w16);
      logic [47:0] st;
      st = time_cursor;
      if ($urandom_range(99) < gap_pct) st = st + 48'($urandom_range(1, 500));
      else if ($urandom_range(199) == 0) st = rand48();
      time_cursor = st + 48'd32;
      send_item(audio_item(ft, make_word(validity, w16), st, time_cursor));
   endtask

   // Pa on B, Pb on W, Pc on M, Pd on W; sometimes damage one of the four.
   task automatic send_burst(input int valid_pct);
      logic [1:0]  fts[4];
      logic [15:0] ws[4];
      logic [15:0] rnd;
      int          damaged;
      int          k;
      rnd     = 16'($urandom);
      fts[0]  = FT_B;
      fts[1]  = FT_W;
      fts[2]  = FT_M;
      fts[3]  = FT_W;
      ws[0]   = PA_WORD;
      ws[1]   = $urandom_range(1) ? PB_WORD : sb.alt_pb;
      ws[2]   = rnd;
      ws[3]   = 16'($urandom);
      damaged = ($urandom_range(99) < 15) ? $urandom_range(3) : -1;
      if (damaged >= 0) begin
         if ($urandom_range(1)) fts[damaged] = 2'($urandom_range(3));
         else ws[damaged] = 16'($urandom);
      end
      for (k = 0; k < 4; k++)
         send_subframe(fts[k], $urandom_range(99) < valid_pct, ws[k]);
   endtask

   // Random S/PDIF stream: B every blk subframes with W/M alternating, bursts
   // at block starts, slipped syncs, noise transactions and drain pauses.
   task automatic run_stream(input int n, input int blk, input int burst_pct,
                             input int valid_pct);
      int          count;
      int          pos;
      int          roll;
      logic [1:0]  ft;
      logic [15:0] w;
      count = 0;
      pos   = 0;
      while (count < n) begin
         roll = $urandom_range(99);
         if (roll < 4) begin
            send_item(status_item(1'($urandom_range(1))));
            count++;
         end else if (roll < 8) begin
            send_item(random_item());
            count++;
         end else if (roll < 9) begin
            wait_for_drain();
         end else if (pos == 0 && $urandom_range(99) < burst_pct) begin
            send_burst(valid_pct);
            pos   += 4;
            count += 4;
         end else begin
            ft = (pos == 0) ? FT_B : ((pos % 2) ? FT_W : FT_M);
            // slip a block sync now and then
            if (pos == 0 && $urandom_range(99) < 4) ft = FT_M;
            w = 16'($urandom);
            if (burst_pct > 0) begin
               case ($urandom_range(9))
                  0: w = PA_WORD;
                  1: w = PB_WORD;
                  2: w = sb.alt_pb;
                  default: ;
               endcase
            end
            send_subframe(ft, $urandom_range(99) < valid_pct, w);
            pos++;
            count++;
         end
         if (pos >= blk) pos = 0;
      end
   endtask

   // Two B preambles with n other subframes between them.
   task automatic run_long_block(input int n);
      int k;
      send_subframe(FT_B, 1'b0, 16'($urandom));
      for (k = 0; k < n; k++)
         send_subframe((k % 2) ? FT_M : FT_W, 1'($urandom_range(1)), 16'($urandom));
      send_subframe(FT_B, 1'b0, 16'($urandom));
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      sb = new();
      reset            <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_index        <= CSR_BLOCK_SUBFRAMES;
      csr_write_data   <= '0;
      req_chan.valid   <= 1'b0;
      req_chan.payload <= '0;
      time_cursor      = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // --- directed: timing gaps and the non-audio flag, default registers ---
      // first subframe: previous end still zero, so no gap
      send_item(audio_item(FT_B, 32'h0000_0000, 48'd0, 48'd0));
      send_item(audio_item(FT_M, 32'hEFFF_FFFF, 48'd100, 48'd132));
      // plain gap
      send_item(audio_item(FT_W, 32'h0000_8000, 48'd200, 48'd232));
      // start before the previous end: length wraps, end at the top of range
      send_item(audio_item(FT_M, 32'h0123_4567, 48'd10, 48'hFFFF_FFFF_FFFF));
      send_item(audio_item(FT_B, 32'h0000_0000, 48'd0, 48'd0));
      // previous end is zero again: no gap despite the jump
      send_item(audio_item(FT_W, 32'h0000_0000, 48'd5, 48'd40));
      // invalid preamble carrying Pa must not start a burst
      send_item(audio_item(FT_INVALID, {4'h0, PA_WORD, 12'h000}, 48'd40, 48'd72));
      // validity bit forces non-audio, which also masks the gap
      send_item(audio_item(FT_W, 32'hFFFF_FFFF, 48'd90, 48'd122));
      send_item(status_item(1'b0));
      send_item(status_item(1'b1));
      send_item(status_item(1'b0));
      send_item(audio_item(FT_W, 32'h0000_0000, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF));

      // --- random PCM stream: no bursts yet, gaps and flag toggling ---
      time_cursor = 48'd1000;
      gap_pct     = 10;
      set_config(10'd8, BURST_PERIOD_BLOCKS_RESET, ALTERNATE_PB_WORD_RESET);
      run_stream(120, 8, 0, 3);

      // --- directed: preamble tracker ---
      gap_pct = 0;
      set_config(10'd4, 6'd1, ALTERNATE_PB_WORD_RESET);
      // repeated Pa restarts, M is skipped, Pb via the alternate word
      send_subframe(FT_B, 1'b0, PA_WORD);
      send_subframe(FT_W, 1'b0, PA_WORD);
      send_subframe(FT_M, 1'b0, 16'h1234);
      send_subframe(FT_W, 1'b0, ALTERNATE_PB_WORD_RESET);
      send_subframe(FT_M, 1'b0, 16'hABC5);
      send_subframe(FT_W, 1'b0, 16'h1800);
      // Pc on the wrong channel
      send_subframe(FT_B, 1'b0, PA_WORD);
      send_subframe(FT_W, 1'b0, PB_WORD);
      send_subframe(FT_W, 1'b0, 16'h0001);
      // Pd on the wrong channel
      send_subframe(FT_B, 1'b1, PA_WORD);
      send_subframe(FT_W, 1'b0, PB_WORD);
      send_subframe(FT_M, 1'b0, 16'hFFFF);
      send_subframe(FT_M, 1'b0, 16'h0000);
      // invalid preamble aborts where Pc is due
      send_subframe(FT_B, 1'b0, PA_WORD);
      send_subframe(FT_W, 1'b0, PB_WORD);
      send_subframe(FT_INVALID, 1'b0, 16'h0011);
      // zero block length, zero period, alternate Pb equal to Pa
      set_config(10'd0, 6'd0, PA_WORD);
      send_subframe(FT_B, 1'b0, PA_WORD);
      send_subframe(FT_W, 1'b0, PA_WORD);
      send_subframe(FT_B, 1'b0, 16'h0003);

      // --- random burst streams under several register settings ---
      gap_pct = 5;
      set_config(10'd6, 6'd1, 16'($urandom));
      run_stream(100, 6, 35, 20);
      set_config(10'd12, 6'd3, 16'h0000);
      run_stream(100, 12, 40, 10);
      set_config(10'd1, 6'd63, 16'hFFFF);
      run_stream(100, 1, 30, 10);
      set_config(10'd16, 6'd0, PA_WORD);
      run_stream(100, 16, 40, 10);
      set_config(10'd10, 6'd2, 16'($urandom));
      run_stream(100, 10, 40, 30);

      // --- one long block at exactly the programmed spacing ---
      set_config(10'd25, BURST_PERIOD_BLOCKS_RESET, ALTERNATE_PB_WORD_RESET);
      run_long_block(24);

      // Drain, let the pipeline settle, then decide.
      wait_for_drain();
      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/core/ibpd_pkg.sv
rtl/core/ibpd_stream_if.sv
rtl/core/ibpd_csr.sv
rtl/core/ibpd_core.sv
rtl/core/iec61937_burst_preamble_detector.sv
tb/tb_top.sv
